[rtl/lted_pkg.sv]
// Shared types and constants for the line / triangle edge intersection block.
// Used by the top level, the divider pipeline and the port checker.
`timescale 1ns / 1ps
package lted_pkg;

  localparam int COORD_W     = 16;            // Q12.4 coordinate
  localparam int AB_W        = COORD_W + 1;   // line coefficients a, b
  localparam int PROD_W      = 2 * COORD_W + 1;
  localparam int C1_W        = 2 * COORD_W + 2;
  localparam int C2_W        = 2 * COORD_W + 3;
  localparam int DET_W       = 2 * COORD_W + 3;
  localparam int NUM_W       = 53;            // numerators and box products
  localparam int DIV_STEPS   = COORD_W;       // quotient magnitude bits
  localparam int FIFO_DEPTH  = 4;
  localparam int NUM_VERT    = 6;
  localparam int IN_DATA_W   = 4 * COORD_W;
  localparam int OUT_DATA_W  = 40;

  localparam logic [2:0] REG_A_X = 3'd0;
  localparam logic [2:0] REG_A_Y = 3'd1;
  localparam logic [2:0] REG_B_X = 3'd2;
  localparam logic [2:0] REG_B_Y = 3'd3;
  localparam logic [2:0] REG_C_X = 3'd4;
  localparam logic [2:0] REG_C_Y = 3'd5;

  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;
  localparam logic [1:0] EDGE_NONE = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AB_W-1:0]    coef_ab_t;
  typedef logic signed [C2_W-1:0]    coef_c_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [1:0] edge_idx;
    logic       pvalid;
    logic       last;
  } res_t;

endpackage

[rtl/lted_div.sv]
// Pipelined restoring divider: one quotient bit per stage, stalls on en low.
// Depends on lted_pkg for widths.
`timescale 1ns / 1ps
module lted_div import lted_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NUM_W-1:0]       num_i,   // non-negative numerator
  input  logic [DET_W-1:0]       den_i,   // positive divisor
  output logic [DIV_STEPS-1:0]   quo_o    // floor(num / den) when it fits in DIV_STEPS bits
);

  localparam int TRIAL_W = NUM_W + 1;

  logic [NUM_W-1:0]     rem_r [DIV_STEPS];
  logic [DET_W-1:0]     den_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0]     rem_in;
    logic [DET_W-1:0]     den_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [TRIAL_W-1:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {1'b0, rem_in} - (TRIAL_W'(den_in) << (DIV_STEPS - 1 - k));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= trial[TRIAL_W-1] ? rem_in : trial[NUM_W-1:0];
        den_r[k] <= den_in;
        quo_r[k] <= quo_in | (DIV_STEPS'(!trial[TRIAL_W-1]) << (DIV_STEPS - 1 - k));
      end
    end
  end

  assign quo_o = quo_r[DIV_STEPS-1];

endmodule

[rtl/line_triangle_edge_intersect_top.sv]
// Each accepted line passes the issue sequencer, the arithmetic pipe, the divider
// and result assembly into the output FIFO; the pipe halts while 3 results wait.
// A new line is accepted as the last edge of the previous one issues; each edge takes
// one slot of the 7-stage arithmetic pipe and the 16-stage divider, so 3 slots per line.
// Reset: synchronous active-low; vertices, box and edge coefficients clear to
// zero, pipeline and output FIFO empty. Coefficients are registered from the vertex registers.
`timescale 1ns / 1ps
module line_triangle_edge_intersect_top import lted_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // line_x0, line_y0, line_x1, line_y1
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // point_x, point_y, edge_index, pad
  output logic                  out_tlast,
  output logic [0:0]            out_tuser,  // point_valid
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_W-1:0]    cfg_wdata
);

  // ---------------- configuration and derived triangle state
  coord_t   vert_r [NUM_VERT];
  coord_t   bmin_x_r, bmin_y_r, bmax_x_r, bmax_y_r;
  coef_ab_t coef_a_r [3];
  coef_ab_t coef_b_r [3];
  coef_c_t  coef_c_r [3];
  coef_ab_t coef_a_nxt [3];
  coef_ab_t coef_b_nxt [3];
  coef_c_t  coef_c_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VERT; i++) vert_r[i] <= '0;
    end else if (cfg_we && (cfg_index < 3'(NUM_VERT))) begin
      vert_r[cfg_index] <= cfg_wdata;
    end
  end

  // edge e runs from vertex e to vertex e+1 (wrapping)
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      coef_a_nxt[e] = AB_W'(vert_r[(e == 2) ? 1 : 2 * e + 3]) - AB_W'(vert_r[2 * e + 1]);
      coef_b_nxt[e] = AB_W'(vert_r[2 * e]) - AB_W'(vert_r[(e == 2) ? 0 : 2 * e + 2]);
      coef_c_nxt[e] = C2_W'(coef_a_nxt[e]) * C2_W'(vert_r[2 * e]) +
                      C2_W'(coef_b_nxt[e]) * C2_W'(vert_r[2 * e + 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bmin_x_r <= '0;
      bmin_y_r <= '0;
      bmax_x_r <= '0;
      bmax_y_r <= '0;
      for (int e = 0; e < 3; e++) begin
        coef_a_r[e] <= '0;
        coef_b_r[e] <= '0;
        coef_c_r[e] <= '0;
      end
    end else begin
      bmin_x_r <= (vert_r[REG_A_X] < vert_r[REG_B_X] ?
                   (vert_r[REG_A_X] < vert_r[REG_C_X] ? vert_r[REG_A_X] : vert_r[REG_C_X]) :
                   (vert_r[REG_B_X] < vert_r[REG_C_X] ? vert_r[REG_B_X] : vert_r[REG_C_X]));
      bmin_y_r <= (vert_r[REG_A_Y] < vert_r[REG_B_Y] ?
                   (vert_r[REG_A_Y] < vert_r[REG_C_Y] ? vert_r[REG_A_Y] : vert_r[REG_C_Y]) :
                   (vert_r[REG_B_Y] < vert_r[REG_C_Y] ? vert_r[REG_B_Y] : vert_r[REG_C_Y]));
      bmax_x_r <= (vert_r[REG_A_X] > vert_r[REG_B_X] ?
                   (vert_r[REG_A_X] > vert_r[REG_C_X] ? vert_r[REG_A_X] : vert_r[REG_C_X]) :
                   (vert_r[REG_B_X] > vert_r[REG_C_X] ? vert_r[REG_B_X] : vert_r[REG_C_X]));
      bmax_y_r <= (vert_r[REG_A_Y] > vert_r[REG_B_Y] ?
                   (vert_r[REG_A_Y] > vert_r[REG_C_Y] ? vert_r[REG_A_Y] : vert_r[REG_C_Y]) :
                   (vert_r[REG_B_Y] > vert_r[REG_C_Y] ? vert_r[REG_B_Y] : vert_r[REG_C_Y]));
      for (int e = 0; e < 3; e++) begin
        coef_a_r[e] <= coef_a_nxt[e];
        coef_b_r[e] <= coef_b_nxt[e];
        coef_c_r[e] <= coef_c_nxt[e];
      end
    end
  end

  // ---------------- issue sequencer: one edge per cycle while the pipe is not halted
  logic       en;
  logic [2:0] fifo_cnt_r;
  logic       busy_r;
  logic [1:0] eidx_r;
  coord_t     it_x0_r, it_y0_r;
  coef_ab_t   it_a1_r, it_b1_r;

  assign en        = (fifo_cnt_r <= 3'(FIFO_DEPTH - 2));
  assign in_tready = en && (!busy_r || eidx_r == EDGE_CA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      eidx_r <= EDGE_AB;
    end else if (en) begin
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1;
        eidx_r <= EDGE_AB;
      end else if (busy_r) begin
        if (eidx_r == EDGE_CA) busy_r <= 1'b0;
        else                   eidx_r <= eidx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      it_x0_r <= in_tdata[COORD_W-1:0];
      it_y0_r <= in_tdata[2*COORD_W-1:COORD_W];
      it_a1_r <= AB_W'($signed(in_tdata[4*COORD_W-1:3*COORD_W])) -
                 AB_W'($signed(in_tdata[2*COORD_W-1:COORD_W]));
      it_b1_r <= AB_W'($signed(in_tdata[COORD_W-1:0])) -
                 AB_W'($signed(in_tdata[3*COORD_W-1:2*COORD_W]));
    end
  end

  // ---------------- arithmetic pipe
  logic [7:1] v_r;
  logic [1:0] e_r [7:1];

  logic signed [PROD_W-1:0] s1_p1_r, s1_p2_r;
  coef_ab_t s1_a1_r, s1_b1_r, s1_a2_r, s1_b2_r;
  coef_c_t  s1_c2_r;

  logic signed [C1_W-1:0] s2_c1_r;
  coef_ab_t s2_a1_r, s2_b1_r, s2_a2_r, s2_b2_r;
  coef_c_t  s2_c2_r;

  logic signed [PROD_W:0] s3_d1_r, s3_d2_r;
  num_t s3_nx1_r, s3_nx2_r, s3_ny1_r, s3_ny2_r;

  logic signed [DET_W-1:0] s4_det_r;
  num_t s4_nx_r, s4_ny_r;

  logic signed [DET_W-1:0] s5_dn_r;
  num_t s5_nx_r, s5_ny_r;
  logic s5_nz_r;

  logic signed [DET_W-1:0] s6_dn_r;
  num_t s6_nx_r, s6_ny_r, s6_lox_r, s6_hix_r, s6_loy_r, s6_hiy_r;
  logic s6_nz_r;

  logic [DET_W-1:0] s7_den_r;
  logic [NUM_W-1:0] s7_mx_r, s7_my_r;
  logic s7_q_r, s7_sx_r, s7_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], busy_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[1] <= eidx_r;
      for (int s = 2; s <= 7; s++) e_r[s] <= e_r[s-1];

      s1_p1_r <= PROD_W'(it_a1_r) * PROD_W'(it_x0_r);
      s1_p2_r <= PROD_W'(it_b1_r) * PROD_W'(it_y0_r);
      s1_a1_r <= it_a1_r;
      s1_b1_r <= it_b1_r;
      s1_a2_r <= coef_a_r[eidx_r];
      s1_b2_r <= coef_b_r[eidx_r];
      s1_c2_r <= coef_c_r[eidx_r];

      s2_c1_r <= C1_W'(s1_p1_r) + C1_W'(s1_p2_r);
      s2_a1_r <= s1_a1_r;
      s2_b1_r <= s1_b1_r;
      s2_a2_r <= s1_a2_r;
      s2_b2_r <= s1_b2_r;
      s2_c2_r <= s1_c2_r;

      s3_d1_r  <= (PROD_W + 1)'(s2_a1_r) * (PROD_W + 1)'(s2_b2_r);
      s3_d2_r  <= (PROD_W + 1)'(s2_a2_r) * (PROD_W + 1)'(s2_b1_r);
      s3_nx1_r <= NUM_W'(s2_b2_r) * NUM_W'(s2_c1_r);
      s3_nx2_r <= NUM_W'(s2_b1_r) * NUM_W'(s2_c2_r);
      s3_ny1_r <= NUM_W'(s2_a1_r) * NUM_W'(s2_c2_r);
      s3_ny2_r <= NUM_W'(s2_a2_r) * NUM_W'(s2_c1_r);

      s4_det_r <= DET_W'(s3_d1_r) - DET_W'(s3_d2_r);
      s4_nx_r  <= s3_nx1_r - s3_nx2_r;
      s4_ny_r  <= s3_ny1_r - s3_ny2_r;

      // make the divisor positive so the box test is a pair of compares
      s5_dn_r <= s4_det_r[DET_W-1] ? -s4_det_r : s4_det_r;
      s5_nx_r <= s4_det_r[DET_W-1] ? -s4_nx_r : s4_nx_r;
      s5_ny_r <= s4_det_r[DET_W-1] ? -s4_ny_r : s4_ny_r;
      s5_nz_r <= (s4_det_r != '0);

      s6_dn_r  <= s5_dn_r;
      s6_nx_r  <= s5_nx_r;
      s6_ny_r  <= s5_ny_r;
      s6_nz_r  <= s5_nz_r;
      s6_lox_r <= NUM_W'(bmin_x_r) * NUM_W'(s5_dn_r);
      s6_hix_r <= NUM_W'(bmax_x_r) * NUM_W'(s5_dn_r);
      s6_loy_r <= NUM_W'(bmin_y_r) * NUM_W'(s5_dn_r);
      s6_hiy_r <= NUM_W'(bmax_y_r) * NUM_W'(s5_dn_r);

      // exact closed-box test: lo*D <= N <= hi*D
      s7_q_r   <= s6_nz_r && (s6_nx_r >= s6_lox_r) && (s6_nx_r <= s6_hix_r) &&
                  (s6_ny_r >= s6_loy_r) && (s6_ny_r <= s6_hiy_r);
      s7_sx_r  <= s6_nx_r[NUM_W-1];
      s7_sy_r  <= s6_ny_r[NUM_W-1];
      s7_mx_r  <= s6_nx_r[NUM_W-1] ? NUM_W'(-s6_nx_r) : NUM_W'(s6_nx_r);
      s7_my_r  <= s6_ny_r[NUM_W-1] ? NUM_W'(-s6_ny_r) : NUM_W'(s6_ny_r);
      s7_den_r <= DET_W'(s6_dn_r);
    end
  end

  // ---------------- divider and matching sideband line
  logic [DIV_STEPS-1:0] qx_mag, qy_mag;

  lted_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num_i (s7_mx_r),
    .den_i (s7_den_r),
    .quo_o (qx_mag)
  );

  lted_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num_i (s7_my_r),
    .den_i (s7_den_r),
    .quo_o (qy_mag)
  );

  typedef struct packed {
    logic [1:0] edge_idx;
    logic       qual;
    logic       sx;
    logic       sy;
  } sb_t;

  logic [DIV_STEPS-1:0] sb_v_r;
  sb_t                  sb_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= '0;
    end else if (en) begin
      sb_v_r <= {sb_v_r[DIV_STEPS-2:0], v_r[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= '{edge_idx: e_r[7], qual: s7_q_r, sx: s7_sx_r, sy: s7_sy_r};
      for (int k = 1; k < DIV_STEPS; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // ---------------- result assembly: hold one point back to place tlast
  sb_t    tail;
  logic   tail_v;
  res_t   nr;
  res_t   held_r, held_nxt;
  logic   held_v_r, held_v_nxt;
  res_t   w0, w1;
  logic   push0, push1, pop;
  res_t   mem_r [FIFO_DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;

  assign tail   = sb_r[DIV_STEPS-1];
  assign tail_v = sb_v_r[DIV_STEPS-1];

  always_comb begin
    nr.x        = tail.sx ? -coord_t'(qx_mag) : coord_t'(qx_mag);
    nr.y        = tail.sy ? -coord_t'(qy_mag) : coord_t'(qy_mag);
    nr.edge_idx = tail.edge_idx;
    nr.pvalid   = 1'b1;
    nr.last     = 1'b0;
    push0       = 1'b0;
    push1       = 1'b0;
    w0          = held_r;
    w1          = nr;
    held_nxt    = held_r;
    held_v_nxt  = held_v_r;
    if (en && tail_v) begin
      if (tail.qual) begin
        if (tail.edge_idx == EDGE_CA) begin
          push0      = 1'b1;
          w1.last    = 1'b1;
          if (held_v_r) begin
            push1 = 1'b1;
          end else begin
            w0 = w1;
          end
          held_v_nxt = 1'b0;
        end else begin
          push0      = held_v_r;
          held_nxt   = nr;
          held_v_nxt = 1'b1;
        end
      end else if (tail.edge_idx == EDGE_CA) begin
        push0 = 1'b1;
        if (!held_v_r) w0 = '0;
        w0.last    = 1'b1;
        held_v_nxt = 1'b0;
      end
    end
  end

  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r   <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      held_v_r   <= held_v_nxt;
      wr_ptr_r   <= wr_ptr_r + {1'b0, push0} + {1'b0, push1};
      rd_ptr_r   <= rd_ptr_r + {1'b0, pop};
      fifo_cnt_r <= fifo_cnt_r + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (push0) mem_r[wr_ptr_r] <= w0;
    if (push1) mem_r[wr_ptr_r + 2'd1] <= w1;
  end

  res_t ores;
  assign ores       = mem_r[rd_ptr_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {(OUT_DATA_W - 2 * COORD_W - 2)'(0), ores.edge_idx, ores.y, ores.x};
  assign out_tlast  = ores.last;
  assign out_tuser  = ores.pvalid;

endmodule

[rtl/lted_chk.sv]
// Port-level checker for the intersection block, bound to the top level.
// Depends on lted_pkg for widths and edge codes.
`timescale 1ns / 1ps
module lted_chk import lted_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic [0:0]            out_tuser
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the no-intersection marker is the only result of its line and is all zero
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("malformed no-intersection result");

  a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*COORD_W+1:2*COORD_W] != EDGE_NONE)
    else $error("edge index out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind line_triangle_edge_intersect_top lted_chk u_lted_chk (.*);
